// ===== rtl/hierarchical_2d_transform_update_core_defines.svh =====
// Assertion macros for the transform update core
`ifndef HIERARCHICAL_2D_TRANSFORM_UPDATE_CORE_DEFINES_SVH
`define HIERARCHICAL_2D_TRANSFORM_UPDATE_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define H2T_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle
`define H2T_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/h2t_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2t_pkg
// Shared constants and arctangent table for the transform update core.
// ----------------------------------------------------------------------------
package h2t_pkg;
    localparam int ENTRY_COUNT   = 16;
    localparam int POSITION_BITS = 24;
    localparam int ANGLE_BITS    = 16;
    localparam int IDX_BITS      = 4;
    localparam int CNT_BITS      = 5;
    localparam int CORDIC_STEPS  = 24;
    localparam int STEP_BITS     = 5;
    localparam int MAX_RESULTS   = 16;
    localparam logic [31:0] GAIN_Q30 = 32'd652032875;
    localparam logic [3:0]  RESET_IN_USE = 4'd4;

    localparam logic REQ_SET    = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/h2t_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2t_cordic
// Iterative rotation of a vector by a turn-fraction angle, one step a cycle.
// ----------------------------------------------------------------------------
module h2t_cordic #(
    parameter int POSITION_BITS = h2t_pkg::POSITION_BITS,
    parameter int ANGLE_BITS    = h2t_pkg::ANGLE_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire signed [POSITION_BITS-1:0]  i_x,
    input  wire signed [POSITION_BITS-1:0]  i_y,
    input  wire        [ANGLE_BITS-1:0]     i_angle,
    output logic                            o_done,
    output logic signed [POSITION_BITS+1:0] o_x,
    output logic signed [POSITION_BITS+1:0] o_y
);
    localparam int WB = POSITION_BITS + 20;
    localparam int PB = POSITION_BITS + 33;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCALE = 4'b0010,
        S_ITER  = 4'b0100,
        S_DONE  = 4'b1000
    } t_cstate;

    t_cstate r_state, n_state;
    logic [h2t_pkg::STEP_BITS-1:0] r_step;
    logic signed [PB-1:0] r_px, r_py;
    logic signed [WB-1:0] r_x, r_y;
    logic signed [32:0]   r_z;

    logic [31:0] w_a;
    logic [31:0] w_az;
    logic        w_flip;
    logic signed [POSITION_BITS:0] w_x0, w_y0;
    logic signed [WB-1:0] w_dx, w_dy;
    logic signed [32:0]   w_at;
    logic signed [WB-1:0] w_rx, w_ry;

    assign w_a    = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_flip = w_a[31] ^ w_a[30];
    assign w_az   = w_flip ? {~w_a[31], w_a[30:0]} : w_a;
    assign w_x0   = w_flip ? -{i_x[POSITION_BITS-1], i_x} : {i_x[POSITION_BITS-1], i_x};
    assign w_y0   = w_flip ? -{i_y[POSITION_BITS-1], i_y} : {i_y[POSITION_BITS-1], i_y};
    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_at   = $signed({1'b0, h2t_pkg::atan_turn(r_step)});
    assign w_rx   = r_x + WB'(32'sh8000);
    assign w_ry   = r_y + WB'(32'sh8000);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SCALE;
            S_SCALE: n_state = S_ITER;
            S_ITER:  if (r_step == h2t_pkg::STEP_BITS'(h2t_pkg::CORDIC_STEPS - 1)) begin
                n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ITER) r_step <= r_step + 1'b1;
            else                   r_step <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_px <= PB'(w_x0) * $signed({1'b0, h2t_pkg::GAIN_Q30});
            r_py <= PB'(w_y0) * $signed({1'b0, h2t_pkg::GAIN_Q30});
            r_z  <= {w_az[31], w_az};
        end else if (r_state == S_SCALE) begin
            r_x <= WB'(r_px >>> 14);
            r_y <= WB'(r_py >>> 14);
        end else if (r_state == S_ITER) begin
            if (!r_z[32]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_x    = (POSITION_BITS+2)'(w_rx >>> 16);
    assign o_y    = (POSITION_BITS+2)'(w_ry >>> 16);
endmodule
`default_nettype wire

// ===== rtl/h2t_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2t_front
// Accept input transactions and queue them for the execution engine.
// ----------------------------------------------------------------------------
module h2t_front #(
    parameter int WIDTH = 82
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ===== rtl/h2t_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "hierarchical_2d_transform_update_core_defines.svh"
// ----------------------------------------------------------------------------
// h2t_engine
// Execute set and update transactions over the transform table.
// ----------------------------------------------------------------------------
module h2t_engine #(
    parameter int ENTRY_COUNT   = h2t_pkg::ENTRY_COUNT,
    parameter int POSITION_BITS = h2t_pkg::POSITION_BITS,
    parameter int ANGLE_BITS    = h2t_pkg::ANGLE_BITS,
    parameter int WIDTH         = 82
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [h2t_pkg::CNT_BITS-1:0] i_in_use,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire [WIDTH-1:0]            i_data,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [h2t_pkg::IDX_BITS-1:0] o_index,
    output logic [POSITION_BITS-1:0]   o_x,
    output logic [POSITION_BITS-1:0]   o_y,
    output logic [ANGLE_BITS-1:0]      o_angle,
    output logic                       o_last
);
    localparam int EB = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int SB = $clog2(ENTRY_COUNT + 2);
    localparam int IB = h2t_pkg::IDX_BITS;
    localparam int CB = h2t_pkg::CNT_BITS;
    localparam int NMAX = (ENTRY_COUNT < h2t_pkg::MAX_RESULTS) ? ENTRY_COUNT
                                                               : h2t_pkg::MAX_RESULTS;
    localparam logic signed [POSITION_BITS+1:0] PHI =
        (POSITION_BITS+2)'((64'sd1 <<< (POSITION_BITS - 1)) - 1);
    localparam logic signed [POSITION_BITS+1:0] PLO =
        -(POSITION_BITS+2)'(64'sd1 <<< (POSITION_BITS - 1));

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_VISIT = 8'b00000010,
        S_LOOK  = 8'b00000100,
        S_ROT   = 8'b00001000,
        S_WAIT  = 8'b00010000,
        S_WRITE = 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_HOLD  = 8'b10000000
    } t_estate;

    t_estate r_state, n_state;
    logic signed [POSITION_BITS-1:0] r_lx [ENTRY_COUNT];
    logic signed [POSITION_BITS-1:0] r_ly [ENTRY_COUNT];
    logic [ANGLE_BITS-1:0]           r_la [ENTRY_COUNT];
    logic                            r_hp [ENTRY_COUNT];
    logic [EB-1:0]                   r_pi [ENTRY_COUNT];
    logic signed [POSITION_BITS-1:0] r_wx [ENTRY_COUNT];
    logic signed [POSITION_BITS-1:0] r_wy [ENTRY_COUNT];
    logic [ANGLE_BITS-1:0]           r_wa [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0]          r_mark;
    logic [EB-1:0]                   r_stk [ENTRY_COUNT+1];
    logic [SB-1:0]                   r_depth;
    logic [CB-1:0]                   r_n, r_i;
    logic [EB-1:0]                   r_cur;
    logic signed [POSITION_BITS-1:0] r_px, r_py;
    logic [ANGLE_BITS-1:0]           r_pa;
    logic                            r_start;
    logic                            r_ov;
    logic [IB-1:0]                   r_oi;
    logic [POSITION_BITS-1:0]        r_ox, r_oy;
    logic [ANGLE_BITS-1:0]           r_oa;
    logic                            r_ol;

    logic [ENTRY_COUNT-1:0] w_clr;
    logic                   w_req;
    logic [IB-1:0]          w_eidx, w_pidx;
    logic [EB-1:0]          w_eix, w_pix, w_cix;
    logic                   w_cdone;
    logic signed [POSITION_BITS+1:0] w_rx, w_ry, w_sx, w_sy;
    logic [EB-1:0]          w_top, w_par;
    logic                   w_push;
    logic [CB-1:0]          w_cap;
    logic                   w_take;

    assign w_req  = i_data[0];
    assign w_eidx = i_data[4:1];
    assign w_pidx = i_data[9:6];
    assign w_eix  = EB'(w_eidx);
    assign w_pix  = EB'(w_pidx);
    assign w_cix  = EB'(r_i);
    assign w_take = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign w_top  = r_stk[r_depth - SB'(1)];
    assign w_par  = r_pi[w_top];
    assign w_push = r_hp[w_top] && !r_mark[w_par] && (r_depth < SB'(ENTRY_COUNT + 1));
    assign w_cap  = (i_in_use > CB'(NMAX)) ? CB'(NMAX) : i_in_use;
    assign w_clr  = '0;
    assign w_sx   = w_rx + (POSITION_BITS+2)'(r_px);
    assign w_sy   = w_ry + (POSITION_BITS+2)'(r_py);

    h2t_cordic #(.POSITION_BITS(POSITION_BITS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_x(r_lx[r_cur]), .i_y(r_ly[r_cur]), .i_angle(r_pa),
        .o_done(w_cdone), .o_x(w_rx), .o_y(w_ry)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_take && w_req == h2t_pkg::REQ_UPDATE) begin
                n_state = (w_cap == '0) ? S_IDLE : S_VISIT;
            end
            S_VISIT: n_state = S_LOOK;
            S_LOOK:  if (!w_push) n_state = S_ROT;
            S_ROT:   n_state = S_WAIT;
            S_WAIT:  if (w_cdone) n_state = S_WRITE;
            S_WRITE: if (r_depth == SB'(1)) begin
                n_state = (r_i == r_n - 1'b1) ? S_EMIT : S_VISIT;
            end else begin
                n_state = S_LOOK;
            end
            S_EMIT:  n_state = S_HOLD;
            S_HOLD:  if (!r_ov || i_ready) begin
                n_state = (r_i == r_n - 1'b1) ? S_IDLE : S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark  <= '0;
            r_depth <= '0;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_n     <= '0;
            for (int k = 0; k < ENTRY_COUNT; k++) begin
                r_hp[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_ROT);
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take && w_req == h2t_pkg::REQ_SET) begin
                        if (32'(w_eidx) < ENTRY_COUNT) begin
                            r_hp[w_eix] <= i_data[5] && (32'(w_pidx) < ENTRY_COUNT);
                        end
                    end else if (w_take) begin
                        r_n    <= w_cap;
                        r_i    <= '0;
                        r_mark <= w_clr;
                    end
                end
                S_VISIT: begin
                    r_depth <= SB'(1);
                end
                S_LOOK: begin
                    if (w_push) begin
                        r_mark[w_par] <= 1'b1;
                        r_depth       <= r_depth + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_depth <= r_depth - 1'b1;
                    if (r_depth == SB'(1)) begin
                        if (r_i == r_n - 1'b1) begin
                            r_i    <= '0;
                            r_mark <= w_clr;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    r_ov <= 1'b1;
                end
                S_HOLD: begin
                    if ((!r_ov || i_ready) && r_i != r_n - 1'b1) r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRY_COUNT; k++) begin
                r_lx[k] <= '0;
                r_ly[k] <= '0;
                r_la[k] <= '0;
                r_pi[k] <= '0;
                r_wx[k] <= '0;
                r_wy[k] <= '0;
                r_wa[k] <= '0;
            end
        end else begin
            if (r_state == S_IDLE && w_take && w_req == h2t_pkg::REQ_SET &&
                32'(w_eidx) < ENTRY_COUNT) begin
                r_lx[w_eix] <= i_data[10 +: POSITION_BITS];
                r_ly[w_eix] <= i_data[10+POSITION_BITS +: POSITION_BITS];
                r_la[w_eix] <= i_data[10+2*POSITION_BITS +: ANGLE_BITS];
                r_pi[w_eix] <= w_pix;
                r_wx[w_eix] <= '0;
                r_wy[w_eix] <= '0;
                r_wa[w_eix] <= '0;
            end
            if (r_state == S_VISIT) r_stk[0] <= w_cix;
            if (r_state == S_LOOK) begin
                if (w_push) begin
                    r_stk[r_depth] <= w_par;
                end else begin
                    r_cur <= w_top;
                    r_px  <= r_hp[w_top] ? r_wx[w_par] : '0;
                    r_py  <= r_hp[w_top] ? r_wy[w_par] : '0;
                    r_pa  <= r_hp[w_top] ? r_wa[w_par] : '0;
                end
            end
            if (r_state == S_WRITE) begin
                r_wx[r_cur] <= (w_sx > PHI) ? PHI[POSITION_BITS-1:0] :
                               (w_sx < PLO) ? PLO[POSITION_BITS-1:0] : w_sx[POSITION_BITS-1:0];
                r_wy[r_cur] <= (w_sy > PHI) ? PHI[POSITION_BITS-1:0] :
                               (w_sy < PLO) ? PLO[POSITION_BITS-1:0] : w_sy[POSITION_BITS-1:0];
                r_wa[r_cur] <= r_pa + r_la[r_cur];
            end
            if (r_state == S_EMIT) begin
                r_oi <= IB'(r_i);
                r_ox <= r_wx[w_cix];
                r_oy <= r_wy[w_cix];
                r_oa <= r_wa[w_cix];
                r_ol <= (r_i == r_n - 1'b1);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_index = r_oi;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_angle = r_oa;
    assign o_last  = r_ol;

    `H2T_ASSERT_IMP(a_stack_bound, i_clk, i_rst_n, 1'b1, r_depth <= SB'(ENTRY_COUNT + 1), "stack overflow")
    `H2T_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_ox), "result lost")
    `H2T_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready, "accept while busy")
endmodule
`default_nettype wire

// ===== rtl/hierarchical_2d_transform_update_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Set transaction: executed by the engine once it leaves the two-entry queue, no result.
// Update pass: for each visited entry a visit, lookup, start, rotation and write,
// with lookup, start, rotation and write also for every parent computed first along the chain.
// Then the results are emitted one at a time, each held until the sink takes it; one transaction at a time.
// Synchronous active-low reset: tables zero, every entry a root, in use 4.
// ----------------------------------------------------------------------------
// hierarchical_2d_transform_update_core
// Hierarchical 2D transform table with an update pass engine.
// ----------------------------------------------------------------------------
module hierarchical_2d_transform_update_core #(
    parameter int ENTRY_COUNT   = h2t_pkg::ENTRY_COUNT,
    parameter int POSITION_BITS = h2t_pkg::POSITION_BITS,
    parameter int ANGLE_BITS    = h2t_pkg::ANGLE_BITS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [4:0]  i_cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // req_type, entry_index, has_parent, parent_index, local_x, local_y, local_angle
    input  wire [((10+2*POSITION_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // result_index, world_x, world_y, world_angle
    output logic [((4+2*POSITION_BITS+ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic       m_axis_tlast
);
    localparam int W  = 10 + 2*POSITION_BITS + ANGLE_BITS;
    localparam int OW = 4 + 2*POSITION_BITS + ANGLE_BITS;
    localparam int OT = ((OW + 7) / 8) * 8;

    logic [h2t_pkg::CNT_BITS-1:0] r_in_use;
    logic             w_qv, w_qr;
    logic [W-1:0]     w_qd;
    logic [3:0]       w_oi;
    logic [POSITION_BITS-1:0] w_ox, w_oy;
    logic [ANGLE_BITS-1:0]    w_oa;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_use <= h2t_pkg::CNT_BITS'(h2t_pkg::RESET_IN_USE);
        else if (i_cfg_valid) r_in_use <= i_cfg_data;
    end

    h2t_front #(.WIDTH(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata[W-1:0]),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qd)
    );

    h2t_engine #(.ENTRY_COUNT(ENTRY_COUNT), .POSITION_BITS(POSITION_BITS),
                 .ANGLE_BITS(ANGLE_BITS), .WIDTH(W)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_use(r_in_use),
        .i_valid(w_qv), .o_ready(w_qr), .i_data(w_qd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_index(w_oi), .o_x(w_ox), .o_y(w_oy), .o_angle(w_oa), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = OT'({w_oa, w_oy, w_ox, w_oi});
endmodule
`default_nettype wire

// ===== bench/hierarchical_2d_transform_update_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_2d_transform_update_core_tb
// Self-checking bench for the transform update core.
// A queue of set, update and in-use writes feeds a clocked driver.
// A clocked monitor recomputes each update pass in a local model of the
// transform table, including the rotation, the parent walk and saturation.
// It then compares every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module hierarchical_2d_transform_update_core_tb;
    localparam int EC = h2t_pkg::ENTRY_COUNT;
    localparam int PB = h2t_pkg::POSITION_BITS;
    localparam int AB = h2t_pkg::ANGLE_BITS;
    localparam int IB = h2t_pkg::IDX_BITS;
    localparam int CB = h2t_pkg::CNT_BITS;
    localparam int NSTEP = h2t_pkg::CORDIC_STEPS;
    localparam int QUIET_CYCLES = 2000;
    localparam longint GAIN = 64'd652032875;
    localparam longint POS_HI = (64'sd1 <<< (PB - 1)) - 1;
    localparam longint POS_LO = -(64'sd1 <<< (PB - 1));
    localparam longint ATAN_TURN [NSTEP] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
    };

    typedef struct {
        bit                   is_cfg;
        logic [CB-1:0]        cfg;
        logic                 req;
        logic [IB-1:0]        entry;
        logic                 has_par;
        logic [IB-1:0]        par;
        logic signed [PB-1:0] lx;
        logic signed [PB-1:0] ly;
        logic [AB-1:0]        ang;
    } t_request;

    typedef struct {
        logic [IB-1:0] idx;
        logic [PB-1:0] wx;
        logic [PB-1:0] wy;
        logic [AB-1:0] wa;
        logic          last;
    } t_world;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tready = 1'b0;
    wire         o_cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [71:0] m_axis_tdata;
    wire         m_axis_tlast;

    hierarchical_2d_transform_update_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // transform table model
    logic [CB-1:0] in_use;
    longint        loc_x [EC];
    longint        loc_y [EC];
    logic [AB-1:0] loc_a [EC];
    bit            par_ok [EC];
    logic [IB-1:0] par_of [EC];
    longint        wld_x [EC];
    longint        wld_y [EC];
    logic [AB-1:0] wld_a [EC];
    bit            marked [EC];

    t_request pending[$];
    t_world   expected_world[$];
    t_request cur_req;
    int       total_reqs = 0;
    int       n_done = 0;
    int       n_popped = 0;
    int       quiet = 0;
    int       errors = 0;

    function automatic void rotate_vec(input longint x0, input longint y0,
                                       input logic [AB-1:0] ang,
                                       output longint rx, output longint ry);
        logic [31:0] a;
        logic [31:0] t;
        longint x, y, z, dx, dy;
        a = {ang, 16'h0};
        t = a + 32'h40000000;
        if (t[31]) begin
            x0 = -x0;
            y0 = -y0;
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        x = (x0 * GAIN) >>> 14;
        y = (y0 * GAIN) >>> 14;
        for (int i = 0; i < NSTEP; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[i];
            end
        end
        rx = (x + 32768) >>> 16;
        ry = (y + 32768) >>> 16;
    endfunction

    function automatic longint clamp_pos(input longint v);
        return v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
    endfunction

    function automatic void compute_world(input int e);
        longint px, py, rx, ry;
        logic [AB-1:0] pa;
        px = 0;
        py = 0;
        pa = '0;
        if (par_ok[e]) begin
            px = wld_x[par_of[e]];
            py = wld_y[par_of[e]];
            pa = wld_a[par_of[e]];
        end
        rotate_vec(loc_x[e], loc_y[e], pa, rx, ry);
        wld_x[e] = clamp_pos(px + rx);
        wld_y[e] = clamp_pos(py + ry);
        wld_a[e] = pa + loc_a[e];
    endfunction

    function automatic void walk_chain(input int start);
        int chain [EC+1];
        int depth;
        int top;
        depth = 1;
        chain[0] = start;
        while (depth > 0) begin
            top = chain[depth-1];
            if (par_ok[top] && !marked[par_of[top]] && depth < EC + 1) begin
                marked[par_of[top]] = 1'b1;
                chain[depth] = par_of[top];
                depth++;
            end else begin
                compute_world(top);
                depth--;
            end
        end
    endfunction

    function automatic void apply_request(input t_request r);
        int n;
        t_world w;
        if (r.req == h2t_pkg::REQ_SET) begin
            loc_x[r.entry] = longint'(r.lx);
            loc_y[r.entry] = longint'(r.ly);
            loc_a[r.entry] = r.ang;
            par_ok[r.entry] = r.has_par;
            par_of[r.entry] = r.par;
            wld_x[r.entry] = 0;
            wld_y[r.entry] = 0;
            wld_a[r.entry] = '0;
        end else begin
            n = in_use > EC ? EC : int'(in_use);
            for (int i = 0; i < EC; i++) marked[i] = 1'b0;
            for (int i = 0; i < n; i++) walk_chain(i);
            for (int i = 0; i < n; i++) begin
                w.idx = IB'(i);
                w.wx = wld_x[i][PB-1:0];
                w.wy = wld_y[i][PB-1:0];
                w.wa = wld_a[i];
                w.last = (i + 1 == n);
                expected_world.push_back(w);
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic check_world(input t_world got);
        t_world w;
        if (expected_world.size() == 0) begin
            report_mismatch($sformatf("unexpected result for entry %0d", got.idx));
        end else begin
            w = expected_world.pop_front();
            if (got.idx !== w.idx)
                report_mismatch($sformatf("index %0d, want %0d", got.idx, w.idx));
            if (got.wx !== w.wx)
                report_mismatch($sformatf("entry %0d x %h, want %h", w.idx, got.wx, w.wx));
            if (got.wy !== w.wy)
                report_mismatch($sformatf("entry %0d y %h, want %h", w.idx, got.wy, w.wy));
            if (got.wa !== w.wa)
                report_mismatch($sformatf("entry %0d angle %h, want %h", w.idx, got.wa, w.wa));
            if (got.last !== w.last)
                report_mismatch($sformatf("entry %0d last %b, want %b", w.idx, got.last, w.last));
        end
    endtask

    // monitor: sample transactions at the rising edge
    always @(posedge i_clk) begin
        t_world got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(cur_req);
                n_done++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                in_use = cur_req.cfg;
                n_done++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx = m_axis_tdata[3:0];
                got.wx = m_axis_tdata[27:4];
                got.wy = m_axis_tdata[51:28];
                got.wa = m_axis_tdata[67:52];
                got.last = m_axis_tlast;
                check_world(got);
            end
            if (s_axis_tvalid || i_cfg_valid || m_axis_tvalid || expected_world.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge i_clk) begin
        bit drv_s, drv_c;
        int idle_s, idle_r;
        drv_s = s_axis_tvalid;
        drv_c = i_cfg_valid;
        if (n_done > n_popped) begin
            void'(pending.pop_front());
            n_popped++;
            drv_s = 1'b0;
            drv_c = 1'b0;
        end
        if (n_popped * 3 < total_reqs) begin
            idle_s = 19;
            idle_r = 53;
        end else if (n_popped * 3 < total_reqs * 2) begin
            idle_s = 53;
            idle_r = 19;
        end else begin
            idle_s = 0;
            idle_r = 0;
        end
        if (i_rst_n && !drv_s && !drv_c && pending.size() > 0) begin
            cur_req = pending[0];
            if (cur_req.is_cfg) begin
                if (expected_world.size() == 0 && quiet >= QUIET_CYCLES) begin
                    drv_c = 1'b1;
                    i_cfg_data <= cur_req.cfg;
                end
            end else if ($urandom_range(99) >= idle_s) begin
                drv_s = 1'b1;
                s_axis_tdata <= {6'b0, cur_req.ang, cur_req.ly, cur_req.lx, cur_req.par,
                                 cur_req.has_par, cur_req.entry, cur_req.req};
            end
        end
        s_axis_tvalid <= drv_s;
        i_cfg_valid <= drv_c;
        m_axis_tready <= ($urandom_range(99) >= idle_r);
    end

    task automatic push_set(input int e, input bit hp, input int p, input longint x,
                            input longint y, input int a);
        t_request r;
        r = '{default: '0};
        r.req = h2t_pkg::REQ_SET;
        r.entry = IB'(e);
        r.has_par = hp;
        r.par = IB'(p);
        r.lx = PB'(x);
        r.ly = PB'(y);
        r.ang = AB'(a);
        pending.push_back(r);
    endtask

    task automatic push_update();
        t_request r;
        r = '{default: '0};
        r.req = h2t_pkg::REQ_UPDATE;
        r.entry = IB'($urandom);
        r.par = IB'($urandom);
        r.has_par = 1'($urandom);
        r.lx = PB'($urandom);
        r.ly = PB'($urandom);
        r.ang = AB'($urandom);
        pending.push_back(r);
    endtask

    task automatic push_in_use(input int v);
        t_request r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg = CB'(v);
        pending.push_back(r);
    endtask

    function automatic longint rand_pos();
        if ($urandom_range(3) == 0)
            return longint'($signed(24'($urandom)));
        return longint'($urandom_range(8000)) - 4000;
    endfunction

    initial begin
        int in_use_list [9];
        in_use = CB'(h2t_pkg::RESET_IN_USE);
        for (int i = 0; i < EC; i++) begin
            loc_x[i] = 0;
            loc_y[i] = 0;
            loc_a[i] = '0;
            par_ok[i] = 1'b0;
            par_of[i] = '0;
            wld_x[i] = 0;
            wld_y[i] = 0;
            wld_a[i] = '0;
            marked[i] = 1'b0;
        end
        push_update();
        push_set(0, 0, 0, POS_HI, POS_LO, 'h4000);
        push_set(1, 1, 0, POS_HI, POS_HI, 'hFFFF);
        push_set(2, 1, 3, -256, 512, 'h8000);
        push_set(3, 1, 2, 1000, -77, 'hC000);
        push_set(4, 0, 15, POS_LO, POS_HI, 'h3FFF);
        push_set(5, 1, 5, 300, 400, 'hBFFF);
        push_set(6, 1, 1, POS_LO, POS_LO, 'h7FFF);
        push_set(7, 1, 6, 12345, -6789, 'h0001);
        push_set(8, 1, 9, -1, 1, 'h4001);
        push_set(9, 1, 10, 65536, 0, 'h1234);
        push_set(10, 1, 8, 0, -65536, 'h8001);
        push_set(11, 1, 12, 777, 888, 'hC001);
        push_set(12, 1, 13, -999, 111, 'h2000);
        push_set(13, 1, 14, 256, 256, 'hE000);
        push_set(14, 1, 4, -512, -512, 'h6000);
        push_set(15, 1, 0, POS_HI, 0, 'hA000);
        push_in_use(16);
        push_update();
        in_use_list = '{16, 1, 0, 31, 17, 0, 0, 0, 16};
        for (int k = 5; k < 8; k++) in_use_list[k] = $urandom_range(16, 1);
        foreach (in_use_list[k]) begin
            push_in_use(in_use_list[k]);
            for (int j = 0; j < 12; j++) begin
                if ($urandom_range(3) == 0)
                    push_update();
                else
                    push_set($urandom_range(15), $urandom_range(1), $urandom_range(15),
                             rand_pos(), rand_pos(), $urandom_range(65535));
            end
            push_update();
        end
        total_reqs = pending.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_popped < total_reqs || expected_world.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_world.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
